// ===== rtl/amr_oad_pkg.sv =====
// shared types, codes and the frame size table of the octet-aligned amr depacketizer
// no dependencies
package amr_oad_pkg;

  localparam int unsigned AMR_OAD_MAX_PAYLOAD = 2048;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE = 2'd2;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_NOT_ENABLED = 3'd1;
  localparam logic [2:0] STATUS_TOO_SHORT   = 3'd2;
  localparam logic [2:0] STATUS_BAD_ILV     = 3'd3;
  localparam logic [2:0] STATUS_BAD_TYPE    = 3'd4;
  localparam logic [2:0] STATUS_LENGTH      = 3'd5;
  localparam logic [2:0] STATUS_OVERFLOW    = 3'd6;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic        last_out;
    logic [2:0]  status;
    logic [3:0]  cmr_value;
    logic [11:0] frame_total;
  } amr_oad_result_t;

  function automatic logic [4:0] amr_frame_size(logic [3:0] ft);
    logic [4:0] sz;
    case (ft)
      4'd0:    sz = 5'd12;
      4'd1:    sz = 5'd13;
      4'd2:    sz = 5'd15;
      4'd3:    sz = 5'd17;
      4'd4:    sz = 5'd19;
      4'd5:    sz = 5'd20;
      4'd6:    sz = 5'd26;
      4'd7:    sz = 5'd31;
      4'd8:    sz = 5'd5;
      default: sz = 5'd0;
    endcase
    return sz;
  endfunction

  function automatic logic amr_type_invalid(logic [3:0] ft);
    return (ft >= 4'd9) && (ft <= 4'd14);
  endfunction

endpackage

// ===== rtl/amr_oad_if.sv =====
// valid/ready channel interfaces for payload words, result words and config writes
// no dependencies
interface amr_oad_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] payload_byte;
  logic       last_byte;
  modport source (output valid, cmd, payload_byte, last_byte, input ready);
  modport sink (input valid, cmd, payload_byte, last_byte, output ready);
  modport monitor (input valid, ready, cmd, payload_byte, last_byte);
endinterface

interface amr_oad_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic        last_out;
  logic [2:0]  status;
  logic [3:0]  cmr_value;
  logic [11:0] frame_total;
  modport source (output valid, kind, out_byte, last_out, status, cmr_value, frame_total,
                  input ready);
  modport sink (input valid, kind, out_byte, last_out, status, cmr_value, frame_total,
                output ready);
  modport monitor (input valid, ready, kind, out_byte, last_out, status, cmr_value,
                   frame_total);
endinterface

interface amr_oad_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

// ===== rtl/amr_oad_store.sv =====
// payload byte memory: one write port, one read port with registered data
// depends on nothing but its parameters
module amr_oad_store #(
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/amr_oad_parser.sv =====
// load side: stores payload words, parses cmr, ill/ilp and toc, builds the status word
// depends on amr_oad_pkg
module amr_oad_parser
  import amr_oad_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = AMR_OAD_MAX_PAYLOAD,
  localparam int unsigned AW = $clog2(MAX_PAYLOAD),
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  input  logic            enable_i,
  input  logic            crc_mode_i,
  input  logic            interleave_i,
  output logic            we_o,
  output logic [AW-1:0]   waddr_o,
  output logic [7:0]      wdata_o,
  output logic            res_valid_o,
  output amr_oad_result_t res_o,
  output logic            start_o,
  output logic [CW-1:0]   frames_o,
  output logic [CW-1:0]   crcs_o
);

  localparam int unsigned TW = CW + 5;
  localparam int unsigned SW = CW + 6;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          toc_open_q, toc_open_d;
  logic [CW-1:0] frame_q, frame_d;
  logic [CW-1:0] nonempty_q, nonempty_d;
  logic [TW-1:0] data_q, data_d;
  logic [2:0]    err_q, err_d;
  logic [3:0]    cmr_q, cmr_d;

  logic [CW-1:0]    hdr;
  logic [3:0]       ft;
  logic [4:0]       fsize;
  logic [CW-1:0]    plen;
  logic [CW-1:0]    crcs;
  logic [SW-1:0]    need;
  logic [2:0]       status;
  logic [CW+11:0]   frame_wide;

  assign hdr   = interleave_i ? CW'(2) : CW'(1);
  assign ft    = byte_i[6:3];
  assign fsize = amr_frame_size(ft);

  always_comb begin
    cnt_d      = cnt_q;
    toc_open_d = toc_open_q;
    frame_d    = (cnt_q == '0) ? '0 : frame_q;
    cmr_d      = (cnt_q == '0) ? 4'd0 : cmr_q;
    nonempty_d = nonempty_q;
    data_d     = data_q;
    err_d      = err_q;
    we_o       = 1'b0;
    if (push_i) begin
      if (cnt_q >= CW'(MAX_PAYLOAD)) begin
        err_d = STATUS_OVERFLOW;
      end else begin
        we_o  = 1'b1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == '0) begin
          cmr_d = byte_i[7:4];
        end else if (cnt_q < hdr) begin
          if ((byte_i[3:0] > byte_i[7:4]) && (err_q == STATUS_OK)) begin
            err_d = STATUS_BAD_ILV;
          end
        end else if (toc_open_q && (err_q == STATUS_OK)) begin
          if (amr_type_invalid(ft)) begin
            err_d      = STATUS_BAD_TYPE;
            toc_open_d = 1'b0;
          end else begin
            if (fsize != 5'd0) begin
              data_d     = data_q + TW'(fsize);
              nonempty_d = nonempty_q + CW'(1);
            end
            frame_d = frame_q + CW'(1);
            if (cnt_q == '0) begin
              frame_d = CW'(1);
            end
            if (!byte_i[7]) begin
              toc_open_d = 1'b0;
            end
          end
        end
      end
    end
  end

  assign crcs = crc_mode_i ? nonempty_d : '0;
  assign plen = (cnt_d > hdr) ? (cnt_d - hdr) : '0;
  assign need = SW'(frame_d) + SW'(crcs) + SW'(data_d);

  always_comb begin
    if (!enable_i) begin
      status = STATUS_NOT_ENABLED;
    end else if (err_d == STATUS_OVERFLOW) begin
      status = STATUS_OVERFLOW;
    end else if (cnt_d < CW'(2)) begin
      status = STATUS_TOO_SHORT;
    end else if (err_d != STATUS_OK) begin
      status = err_d;
    end else if (need > SW'(plen)) begin
      status = STATUS_LENGTH;
    end else begin
      status = STATUS_OK;
    end
  end

  assign frame_wide = {12'd0, frame_d};

  always_comb begin
    res_o             = '0;
    res_o.kind        = KIND_STATUS;
    res_o.status      = status;
    res_o.cmr_value   = cmr_d;
    res_o.frame_total = frame_wide[11:0];
  end

  assign res_valid_o = push_i && last_i;
  assign start_o     = res_valid_o && (status == STATUS_OK) && (frame_d != '0);
  assign frames_o    = frame_d;
  assign crcs_o      = crcs;
  assign waddr_o     = cnt_q[AW-1:0];
  assign wdata_o     = byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      toc_open_q <= 1'b1;
      frame_q    <= '0;
      nonempty_q <= '0;
      data_q     <= '0;
      err_q      <= STATUS_OK;
      cmr_q      <= 4'd0;
    end else if (push_i) begin
      frame_q <= frame_d;
      cmr_q   <= cmr_d;
      if (last_i) begin
        cnt_q      <= '0;
        toc_open_q <= 1'b1;
        nonempty_q <= '0;
        data_q     <= '0;
        err_q      <= STATUS_OK;
      end else begin
        cnt_q      <= cnt_d;
        toc_open_q <= toc_open_d;
        nonempty_q <= nonempty_d;
        data_q     <= data_d;
        err_q      <= err_d;
      end
    end
  end

endmodule

// ===== rtl/amr_oad_drain.sv =====
// drain side: walks toc entries and frame data in the payload memory, one word per request
// depends on amr_oad_pkg
module amr_oad_drain
  import amr_oad_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = AMR_OAD_MAX_PAYLOAD,
  localparam int unsigned AW = $clog2(MAX_PAYLOAD),
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            interleave_i,
  input  logic [CW-1:0]   frames_i,
  input  logic [CW-1:0]   crcs_i,
  input  logic            push_i,
  input  logic            req_i,
  input  logic [7:0]      rdata_i,
  output logic            re_o,
  output logic [AW-1:0]   raddr_o,
  output logic            busy_o,
  output logic            res_valid_o,
  output amr_oad_result_t res_o
);

  logic          active_q, active_d;
  logic          pend_q, pend_d;
  logic          pend_toc_q, pend_toc_d;
  logic          past_q, past_d;
  logic [CW-1:0] toc_q, toc_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] frames_q, frames_d;
  logic [4:0]    left_q, left_d;

  logic [CW-1:0] addr;
  logic [CW-1:0] hdr;
  logic [CW+1:0] ptr_start;
  logic [7:0]    word;
  logic [4:0]    left_now;

  assign hdr       = interleave_i ? CW'(2) : CW'(1);
  assign ptr_start = (CW+2)'(hdr) + (CW+2)'(frames_i) + (CW+2)'(crcs_i);
  assign word      = past_q ? 8'd0 : rdata_i;

  always_comb begin
    active_d    = active_q;
    pend_toc_d  = pend_toc_q;
    toc_d       = toc_q;
    ptr_d       = ptr_q;
    frames_d    = frames_q;
    left_d      = left_q;
    left_now    = left_q;
    addr        = toc_q;
    re_o        = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_DATA;

    if (pend_q) begin
      if (pend_toc_q) begin
        res_o.out_byte = {1'b0, word[6:0]};
        left_now       = amr_frame_size(word[6:3]);
      end else begin
        res_o.out_byte = word;
      end
      left_d      = left_now;
      res_valid_o = 1'b1;
      if ((frames_q == '0) && (left_now == 5'd0)) begin
        res_o.last_out = 1'b1;
        active_d       = 1'b0;
      end
    end

    pend_d = req_i && active_q;
    if (pend_d) begin
      re_o = 1'b1;
      if (left_q != 5'd0) begin
        addr       = ptr_q;
        ptr_d      = ptr_q + CW'(1);
        left_d     = left_q - 5'd1;
        pend_toc_d = 1'b0;
      end else begin
        toc_d      = toc_q + CW'(1);
        pend_toc_d = 1'b1;
        if (frames_q != '0) begin
          frames_d = frames_q - CW'(1);
        end
      end
    end

    if (push_i) begin
      active_d = 1'b0;
    end
    if (start_i) begin
      active_d = 1'b1;
      toc_d    = hdr;
      ptr_d    = ptr_start[CW-1:0];
      frames_d = frames_i;
      left_d   = 5'd0;
    end
  end

  assign past_d  = addr >= CW'(MAX_PAYLOAD);
  assign raddr_o = addr[AW-1:0];
  assign busy_o  = pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      pend_q     <= 1'b0;
      pend_toc_q <= 1'b0;
      past_q     <= 1'b0;
      toc_q      <= '0;
      ptr_q      <= '0;
      frames_q   <= '0;
      left_q     <= 5'd0;
    end else begin
      active_q   <= active_d;
      pend_q     <= pend_d;
      pend_toc_q <= pend_toc_d;
      past_q     <= past_d;
      toc_q      <= toc_d;
      ptr_q      <= ptr_d;
      frames_q   <= frames_d;
      left_q     <= left_d;
    end
  end

endmodule

// ===== rtl/amr_octet_aligned_depacketizer.sv =====
// top level of the octet-aligned amr payload depacketizer: config registers, output register
// depends on amr_oad_pkg, amr_oad_if, amr_oad_store, amr_oad_parser, amr_oad_drain
//
// Push words (cmd 0) are taken one per cycle when not stalled; toc counting and length checks
// run as each byte is written into the payload memory, and the word marked last returns a
// status word in the next cycle. Drain words (cmd 1) stall input: the payload memory read is
// registered, and the toc byte read sets the size of the frame that follows. The output
// register holds one result, so a new word is taken only when it is empty or is read by the
// sink in the same cycle; a result that waits on the sink holds off every word. The memory
// needs no clearing after reset; only bytes of the current payload are ever read back.
module amr_octet_aligned_depacketizer
  import amr_oad_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = AMR_OAD_MAX_PAYLOAD
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  amr_oad_in_if.sink           in_i,
  amr_oad_out_if.source        out_o,
  amr_oad_cfg_if.sink          cfg_i
);

  localparam int unsigned AW = $clog2(MAX_PAYLOAD);
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

  logic enable_q, crc_mode_q, interleave_q;

  logic            accept, push, req;
  logic            busy;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;
  logic            re;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;
  logic            p_valid, d_valid;
  amr_oad_result_t p_res, d_res;
  logic            start;
  logic [CW-1:0]   frames, crcs;

  logic            out_valid_q, out_valid_d;
  amr_oad_result_t out_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      crc_mode_q   <= 1'b0;
      interleave_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ENABLE:     enable_q     <= cfg_i.data;
        CFG_CRC_MODE:   crc_mode_q   <= cfg_i.data;
        CFG_INTERLEAVE: interleave_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_i.ready = !busy && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign push       = accept && (in_i.cmd == CMD_PUSH);
  assign req        = accept && (in_i.cmd == CMD_DRAIN);

  amr_oad_store #(
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  amr_oad_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .byte_i       (in_i.payload_byte),
    .last_i       (in_i.last_byte),
    .enable_i     (enable_q),
    .crc_mode_i   (crc_mode_q),
    .interleave_i (interleave_q),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .res_valid_o  (p_valid),
    .res_o        (p_res),
    .start_o      (start),
    .frames_o     (frames),
    .crcs_o       (crcs)
  );

  amr_oad_drain #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_drain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .interleave_i (interleave_q),
    .frames_i     (frames),
    .crcs_i       (crcs),
    .push_i       (push),
    .req_i        (req),
    .rdata_i      (rdata),
    .re_o         (re),
    .raddr_o      (raddr),
    .busy_o       (busy),
    .res_valid_o  (d_valid),
    .res_o        (d_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (p_valid || d_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_valid) begin
      out_q <= p_res;
    end else if (d_valid) begin
      out_q <= d_res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.out_byte    = out_q.out_byte;
  assign out_o.last_out    = out_q.last_out;
  assign out_o.status      = out_q.status;
  assign out_o.cmr_value   = out_q.cmr_value;
  assign out_o.frame_total = out_q.frame_total;

endmodule

// ===== rtl/amr_oad_checker.sv =====
// port-level checks of the depacketizer, bound to the top level
// depends on amr_oad_pkg, amr_octet_aligned_depacketizer
module amr_oad_port_checks
  import amr_oad_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_cmd_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic [7:0]  out_byte_i,
  input logic        out_last_i,
  input logic [2:0]  out_status_i,
  input logic [3:0]  out_cmr_i,
  input logic [11:0] out_frames_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_kind_i) && $stable(out_status_i))
    else $error("result word changed while stalled");

  a_status_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_STATUS) |-> (out_byte_i == 8'd0)
      && !out_last_i)
    else $error("status word carries data fields");

  a_data_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_DATA) |-> (out_status_i == STATUS_OK)
      && (out_cmr_i == 4'd0) && (out_frames_i == 12'd0))
    else $error("data word carries status fields");

  a_status_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == CMD_PUSH) && in_last_i
      |=> out_valid_i && (out_kind_i == KIND_STATUS))
    else $error("no status word after last payload byte");

endmodule

bind amr_octet_aligned_depacketizer amr_oad_port_checks u_amr_oad_port_checks (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_cmd_i     (in_i.cmd),
  .in_last_i    (in_i.last_byte),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_kind_i   (out_o.kind),
  .out_byte_i   (out_o.out_byte),
  .out_last_i   (out_o.last_out),
  .out_status_i (out_o.status),
  .out_cmr_i    (out_o.cmr_value),
  .out_frames_i (out_o.frame_total)
);
